// ----- rtl/core/pcbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared constants for the certificate bundle parser: status codes, header bit
// fields, body check values, packet slots, their tags and minimum body lengths.
// ----------------------------------------------------------------------------
package pcbp_pkg;

	// Status codes of the result
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_HEADER = 3'd1;
	localparam logic [2:0] ST_LENGTH = 3'd2;
	localparam logic [2:0] ST_TRUNC  = 3'd3;
	localparam logic [2:0] ST_TAG    = 3'd4;
	localparam logic [2:0] ST_BODY   = 3'd5;
	localparam logic [2:0] ST_TRAIL  = 3'd6;

	// Old-format length type codes
	localparam logic [1:0] OLD_LEN_ONE  = 2'd0;
	localparam logic [1:0] OLD_LEN_TWO  = 2'd1;
	localparam logic [1:0] OLD_LEN_FOUR = 2'd2;

	// New-format length octet bounds
	localparam logic [7:0] NEW_LEN_TWO_MIN  = 8'd192;
	localparam logic [7:0] NEW_LEN_TWO_MAX  = 8'd223;
	localparam logic [7:0] NEW_LEN_FIVE     = 8'd255;

	// Body content checks
	localparam logic [7:0] VERSION_4    = 8'h04;
	localparam logic [7:0] SIG_TYPE_MIN = 8'h10;
	localparam logic [7:0] SIG_TYPE_MAX = 8'h13;

	// Packet slots in bundle order
	localparam logic [1:0] PKT_KEY = 2'd0;
	localparam logic [1:0] PKT_UID = 2'd1;
	localparam logic [1:0] PKT_SIG = 2'd2;
	localparam logic [1:0] PKT_END = 2'd3;

	// Expected tag for each packet slot
	function automatic logic [5:0] want_tag(input logic [1:0] slot);
		logic [5:0] t;
		case (slot)
			PKT_KEY: t = 6'd6;
			PKT_UID: t = 6'd13;
			default: t = 6'd2;
		endcase
		return t;
	endfunction

	// Minimum body length for each packet slot
	function automatic logic [2:0] min_body(input logic [1:0] slot);
		logic [2:0] m;
		case (slot)
			PKT_SIG: m = 3'd6;
			default: m = 3'd1;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pgp_cert_bundle_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgp_cert_bundle_parser
// Streaming OpenPGP packet header parser for a key / user ID / signature
// certificate bundle.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and gives one result transaction,
// registered, in the cycle after the byte marked last is accepted. Every byte is
// handled by a single pass of header and body decode logic acting on the
// parser registers, so the sustained rate is one byte per clock; the only
// stall comes from a result that is still waiting in the output register
// while result_ready is low. After the last byte the parser returns to its
// reset state, ready for the next bundle subject to that same stall. On any
// error the status field carries the first error found and every other
// result field is zero.
module pgp_cert_bundle_parser
	import pcbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       status,
	output logic [7:0]       cert_type,
	output logic [31:0]      key_body_offset,
	output logic [31:0]      key_body_length,
	output logic [31:0]      uid_offset,
	output logic [31:0]      uid_length,
	output logic [31:0]      sig_packet_offset,
	output logic [31:0]      sig_packet_length,
	output logic [31:0]      sig_body_offset,
	output logic [31:0]      sig_body_length
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_NEWLEN,
		PH_TWOLEN,
		PH_MULTI,
		PH_BODY,
		PH_DONE
	} phase_t;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [1:0]  pkt_q, pkt_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  len_left_q, len_left_d;
	logic [31:0] remain_q, remain_d;
	logic [1:0]  bidx_q, bidx_d;
	logic [31:0] pos_q, pos_d;
	logic [5:0]  tag_q, tag_d;
	logic [2:0]  err_q, err_d;
	logic [7:0]  sig_type_q, sig_type_d;
	logic [31:0] key_off_q, key_off_d, key_len_q, key_len_d;
	logic [31:0] uid_off_q, uid_off_d, uid_len_q, uid_len_d;
	logic [31:0] sigp_off_q, sigp_off_d, sigp_len_q, sigp_len_d;
	logic [31:0] sigb_off_q, sigb_off_d, sigb_len_q, sigb_len_d;

	// Result register
	logic        result_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  cert_type_q;
	logic [31:0] key_off_r_q, key_len_r_q, uid_off_r_q, uid_len_r_q;
	logic [31:0] sigp_off_r_q, sigp_len_r_q, sigb_off_r_q, sigb_len_r_q;

	logic        accept;
	logic        hdr_done;
	logic [31:0] hdr_len;
	logic [31:0] body_start;
	logic [31:0] remain_dec;
	logic [2:0]  left_dec;
	logic        body_bad;
	logic [2:0]  fin_status;
	logic        fin_ok;

	assign byte_ready = !result_valid_q || result_ready;
	assign accept     = byte_valid && byte_ready;
	assign body_start = pos_q + 32'd1;
	assign remain_dec = (remain_q != '0) ? remain_q - 32'd1 : remain_q;
	assign left_dec   = (len_left_q != '0) ? len_left_q - 3'd1 : len_left_q;

	// Decode one byte against the current parser state
	always_comb begin
		phase_d    = phase_q;
		pkt_d      = pkt_q;
		acc_d      = acc_q;
		len_left_d = len_left_q;
		remain_d   = remain_q;
		bidx_d     = bidx_q;
		tag_d      = tag_q;
		err_d      = err_q;
		sig_type_d = sig_type_q;
		key_off_d  = key_off_q;
		key_len_d  = key_len_q;
		uid_off_d  = uid_off_q;
		uid_len_d  = uid_len_q;
		sigp_off_d = sigp_off_q;
		sigp_len_d = sigp_len_q;
		sigb_off_d = sigb_off_q;
		sigb_len_d = sigb_len_q;
		hdr_done   = 1'b0;
		hdr_len    = '0;
		body_bad   = 1'b0;

		if (err_q == ST_OK) begin
			if (pos_q == '1) begin
				err_d = ST_TRUNC;
			end else begin
				unique case (phase_q)
					PH_TAG: begin
						if (!data_byte[7]) begin
							err_d = ST_HEADER;
						end else begin
							if (pkt_q == PKT_SIG) sigp_off_d = pos_q;
							acc_d = '0;
							if (data_byte[6]) begin
								tag_d   = data_byte[5:0];
								phase_d = PH_NEWLEN;
							end else begin
								tag_d = {2'b00, data_byte[5:2]};
								case (data_byte[1:0])
									OLD_LEN_ONE: begin
										len_left_d = 3'd1;
										phase_d    = PH_MULTI;
									end
									OLD_LEN_TWO: begin
										len_left_d = 3'd2;
										phase_d    = PH_MULTI;
									end
									OLD_LEN_FOUR: begin
										len_left_d = 3'd4;
										phase_d    = PH_MULTI;
									end
									default: err_d = ST_LENGTH;
								endcase
							end
						end
					end
					PH_NEWLEN: begin
						if (data_byte < NEW_LEN_TWO_MIN) begin
							hdr_done = 1'b1;
							hdr_len  = {24'd0, data_byte};
						end else if (data_byte <= NEW_LEN_TWO_MAX) begin
							acc_d   = {19'd0, data_byte[4:0], 8'd0};
							phase_d = PH_TWOLEN;
						end else if (data_byte == NEW_LEN_FIVE) begin
							len_left_d = 3'd4;
							phase_d    = PH_MULTI;
						end else begin
							err_d = ST_LENGTH;
						end
					end
					PH_TWOLEN: begin
						hdr_done = 1'b1;
						hdr_len  = acc_q + {24'd0, data_byte} + 32'd192;
					end
					PH_MULTI: begin
						acc_d      = {acc_q[23:0], data_byte};
						len_left_d = left_dec;
						if (left_dec == '0) begin
							hdr_done = 1'b1;
							hdr_len  = {acc_q[23:0], data_byte};
						end
					end
					PH_BODY: begin
						// Version byte of key and signature, then signature type
						if (bidx_q == 2'd0 && (pkt_q == PKT_KEY || pkt_q == PKT_SIG)
							&& data_byte != VERSION_4) begin
							body_bad = 1'b1;
						end
						if (bidx_q == 2'd1 && pkt_q == PKT_SIG) begin
							sig_type_d = data_byte;
							if (data_byte < SIG_TYPE_MIN || data_byte > SIG_TYPE_MAX)
								body_bad = 1'b1;
						end
						if (body_bad) begin
							err_d = ST_BODY;
						end else begin
							if (bidx_q != 2'd2) bidx_d = bidx_q + 2'd1;
							remain_d = remain_dec;
							if (remain_dec == '0) begin
								pkt_d   = pkt_q + 2'd1;
								phase_d = (pkt_q + 2'd1 == PKT_END) ? PH_DONE : PH_TAG;
							end
						end
					end
					default: err_d = ST_TRAIL;
				endcase
			end
		end

		// Check a completed header and record the packet layout
		if (hdr_done) begin
			if (pkt_q == PKT_END) begin
				err_d = ST_TRAIL;
			end else if (tag_q != want_tag(pkt_q)) begin
				err_d = ST_TAG;
			end else if (hdr_len < {29'd0, min_body(pkt_q)}) begin
				err_d = ST_BODY;
			end else begin
				case (pkt_q)
					PKT_KEY: begin
						key_off_d = body_start;
						key_len_d = hdr_len;
					end
					PKT_UID: begin
						uid_off_d = body_start;
						uid_len_d = hdr_len;
					end
					default: begin
						sigb_off_d = body_start;
						sigb_len_d = hdr_len;
						sigp_len_d = (body_start - sigp_off_q) + hdr_len;
					end
				endcase
				remain_d = hdr_len;
				bidx_d   = 2'd0;
				phase_d  = PH_BODY;
			end
		end

		pos_d = (pos_q != '1) ? pos_q + 32'd1 : pos_q;
	end

	// Final status for a last byte
	assign fin_status = (err_d == ST_OK && phase_d != PH_DONE) ? ST_TRUNC : err_d;
	assign fin_ok     = (fin_status == ST_OK);

	// Hold parser state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_TAG;
			pkt_q          <= '0;
			acc_q          <= '0;
			len_left_q     <= '0;
			remain_q       <= '0;
			bidx_q         <= '0;
			pos_q          <= '0;
			tag_q          <= '0;
			err_q          <= ST_OK;
			sig_type_q     <= '0;
			key_off_q      <= '0;
			key_len_q      <= '0;
			uid_off_q      <= '0;
			uid_len_q      <= '0;
			sigp_off_q     <= '0;
			sigp_len_q     <= '0;
			sigb_off_q     <= '0;
			sigb_len_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// Raise valid on a last byte, drop it once the result is taken
			if (accept && last) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last) begin
					// Return to the start of a bundle
					phase_q        <= PH_TAG;
					pkt_q          <= '0;
					acc_q          <= '0;
					len_left_q     <= '0;
					remain_q       <= '0;
					bidx_q         <= '0;
					pos_q          <= '0;
					tag_q          <= '0;
					err_q          <= ST_OK;
					sig_type_q     <= '0;
					key_off_q      <= '0;
					key_len_q      <= '0;
					uid_off_q      <= '0;
					uid_len_q      <= '0;
					sigp_off_q     <= '0;
					sigp_len_q     <= '0;
					sigb_off_q     <= '0;
					sigb_len_q     <= '0;
				end else begin
					phase_q    <= phase_d;
					pkt_q      <= pkt_d;
					acc_q      <= acc_d;
					len_left_q <= len_left_d;
					remain_q   <= remain_d;
					bidx_q     <= bidx_d;
					pos_q      <= pos_d;
					tag_q      <= tag_d;
					err_q      <= err_d;
					sig_type_q <= sig_type_d;
					key_off_q  <= key_off_d;
					key_len_q  <= key_len_d;
					uid_off_q  <= uid_off_d;
					uid_len_q  <= uid_len_d;
					sigp_off_q <= sigp_off_d;
					sigp_len_q <= sigp_len_d;
					sigb_off_q <= sigb_off_d;
					sigb_len_q <= sigb_len_d;
				end
			end
		end
	end

	// Result payload: zero every field but status on an error
	always_ff @(posedge clk) begin
		if (accept && last) begin
			status_q     <= fin_status;
			cert_type_q  <= fin_ok ? sig_type_d : '0;
			key_off_r_q  <= fin_ok ? key_off_d : '0;
			key_len_r_q  <= fin_ok ? key_len_d : '0;
			uid_off_r_q  <= fin_ok ? uid_off_d : '0;
			uid_len_r_q  <= fin_ok ? uid_len_d : '0;
			sigp_off_r_q <= fin_ok ? sigp_off_d : '0;
			sigp_len_r_q <= fin_ok ? sigp_len_d : '0;
			sigb_off_r_q <= fin_ok ? sigb_off_d : '0;
			sigb_len_r_q <= fin_ok ? sigb_len_d : '0;
		end
	end

	assign result_valid      = result_valid_q;
	assign status            = status_q;
	assign cert_type         = cert_type_q;
	assign key_body_offset   = key_off_r_q;
	assign key_body_length   = key_len_r_q;
	assign uid_offset        = uid_off_r_q;
	assign uid_length        = uid_len_r_q;
	assign sig_packet_offset = sigp_off_r_q;
	assign sig_packet_length = sigp_len_r_q;
	assign sig_body_offset   = sigb_off_r_q;
	assign sig_body_length   = sigb_len_r_q;

endmodule
`default_nettype wire
